>>> hdl/bb3_pkg.sv
// shared constants, types and helpers of the rgb 3x3 box blur
package bb3_pkg;

  localparam int COL_W      = 11;   // column counter, out_x
  localparam int ROW_W      = 12;   // row counter, out_y
  localparam int WID_W      = 12;   // frame_width register
  localparam int HGT_W      = 13;   // frame_height register
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int LB_AW      = $clog2(MAX_WIDTH);
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SUM_W      = 12;   // nine 8-bit values plus rounding bias

  // divide by nine: (s + 4) * 3641 >> 15 is exact for s + 4 below 32768
  localparam int ROUND_BIAS = 4;
  localparam int RECIP      = 3641;
  localparam int RECIP_SH   = 15;

  // lowest column and row of the incoming pixel whose centre result gets the blur, and the right and bottom gap
  localparam int INNER_MIN  = 3;
  localparam int EDGE_GAP   = 2;

  // result slots of one pixel, in emission order
  localparam int RES_CENTER = 0;    // (c-1, r-1)
  localparam int RES_RIGHT  = 1;    // (c,   r-1) at the end of a row
  localparam int RES_BELOW  = 2;    // (c-1, r)   in the last row
  localparam int RES_CORNER = 3;    // (c,   r)   last pixel of the frame
  localparam int RES_N      = 4;

  // configuration port
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

  // stream payloads
  localparam int IN_DATA_W  = 24;
  localparam int OUT_BITS   = COL_W + ROW_W + PIX_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t             px;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } front_item_t;

  typedef struct packed {
    logic [RES_N-1:0] mask;
    logic             inner;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } plan_t;

  typedef struct packed {
    plan_t            plan;
    logic [SUM_W-1:0] tot_red;
    logic [SUM_W-1:0] tot_green;
    logic [SUM_W-1:0] tot_blue;
    pix_t             p4;
    pix_t             p5;
    pix_t             p7;
    pix_t             p8;
  } calc_item_t;

  function automatic logic [CHAN_W-1:0] div9_round(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0]   biased;
    logic [2*SUM_W-1:0] prod;
    biased = s + SUM_W'(ROUND_BIAS);
    prod   = (2*SUM_W)'(biased) * (2*SUM_W)'(RECIP);
    return prod[RECIP_SH +: CHAN_W];
  endfunction

endpackage

>>> hdl/bb3_ram.sv
// simple dual-port ram, registered read, write data forwarded on a same-address read
module bb3_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> hdl/bb3_front.sv
// raster counters, input register and the two line buffers
module bb3_front import bb3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [WID_W-1:0]  w_lim,
  input  logic [HGT_W-1:0]  h_lim,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  pix_t              in_px,
  output logic              s0_valid,
  output front_item_t       s0_item,
  output pix_t              up1,
  output pix_t              up2,
  input  logic              s1_ready
);

  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic             accept;
  logic             wrap_col;
  logic [HGT_W-1:0] row_a;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [WID_W-1:0] col_inc;
  logic [HGT_W-1:0] row_inc;
  logic             wb_pending;

  assign s_tready = !s0_valid || s1_ready;
  assign accept   = s_tvalid && s_tready;

  // counters left out of range by a size change: a column restarts at the next row, a row at row 0
  always_comb begin
    wrap_col = WID_W'(column_count) >= w_lim;
    row_a    = wrap_col ? HGT_W'(row_count) + HGT_W'(1) : HGT_W'(row_count);
    col_cur  = wrap_col ? '0 : column_count;
    row_cur  = (row_a >= h_lim) ? '0 : row_a[ROW_W-1:0];
    col_inc  = WID_W'(col_cur) + WID_W'(1);
    row_inc  = HGT_W'(row_cur) + HGT_W'(1);
    if (col_inc >= w_lim) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= h_lim) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s0_valid     <= 1'b0;
      wb_pending   <= 1'b0;
    end else begin
      wb_pending <= accept;
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        s0_valid     <= 1'b1;
      end else if (s1_ready) begin
        s0_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_item <= '{px: in_px, col: col_cur, row: row_cur};
    end
  end

  // write-back in the cycle after the read: older takes what newer held
  bb3_ram #(.DATA_W(PIX_W), .ADDR_W(LB_AW)) older_row_store (
    .clk     (clk),
    .wr_en   (wb_pending),
    .wr_addr (s0_item.col[LB_AW-1:0]),
    .wr_data (up1),
    .rd_en   (accept),
    .rd_addr (col_cur[LB_AW-1:0]),
    .rd_data (up2)
  );

  bb3_ram #(.DATA_W(PIX_W), .ADDR_W(LB_AW)) newer_row_store (
    .clk     (clk),
    .wr_en   (wb_pending),
    .wr_addr (s0_item.col[LB_AW-1:0]),
    .wr_data (s0_item.px),
    .rd_en   (accept),
    .rd_addr (col_cur[LB_AW-1:0]),
    .rd_data (up1)
  );

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> WID_W'(column_count) < $past(w_lim))
    else $error("column counter left the frame width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> HGT_W'(row_count) < $past(h_lim))
    else $error("row counter left the frame height");

endmodule

>>> hdl/bb3_window.sv
// 3x3 window, result plan per pixel and channel sums
module bb3_window import bb3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [WID_W-1:0] w_lim,
  input  logic [HGT_W-1:0] h_lim,
  input  logic             s0_valid,
  input  front_item_t      s0_item,
  input  pix_t             up1,
  input  pix_t             up2,
  output logic             s1_ready,
  output logic             s2_valid,
  output calc_item_t       s2_item,
  input  logic             s2_free
);

  logic             s1_valid;
  plan_t            s1_plan, plan_new;
  pix_t             win [9];
  logic             take, move, s2_ready;
  logic             c_any, r_any, c_last, r_last;
  logic [SUM_W-1:0] tot_red, tot_green, tot_blue;

  function automatic logic [SUM_W-1:0] add3(input logic [SUM_W-1:0] a,
                                            input logic [SUM_W-1:0] b,
                                            input logic [SUM_W-1:0] c);
    return a + b + c;
  endfunction

  assign s2_ready = !s2_valid || s2_free;
  assign s1_ready = !s1_valid || s2_ready;
  assign take     = s0_valid && s1_ready;
  assign move     = s1_valid && s2_ready;

  always_comb begin
    c_any  = s0_item.col != '0;
    r_any  = s0_item.row != '0;
    c_last = WID_W'(s0_item.col) == w_lim - WID_W'(1);
    r_last = HGT_W'(s0_item.row) == h_lim - HGT_W'(1);
    plan_new.mask             = '0;
    plan_new.mask[RES_CENTER] = r_any && c_any;
    plan_new.mask[RES_RIGHT]  = r_any && c_last;
    plan_new.mask[RES_BELOW]  = r_last && c_any;
    plan_new.mask[RES_CORNER] = r_last && c_last;
    plan_new.inner = (s0_item.col >= COL_W'(INNER_MIN)) &&
                     (s0_item.row >= ROW_W'(INNER_MIN)) &&
                     (WID_W'(s0_item.col) + WID_W'(EDGE_GAP) <= w_lim) &&
                     (HGT_W'(s0_item.row) + HGT_W'(EDGE_GAP) <= h_lim);
    plan_new.col = s0_item.col;
    plan_new.row = s0_item.row;
  end

  always_comb begin
    tot_red   = add3(add3(SUM_W'(win[0].red), SUM_W'(win[1].red), SUM_W'(win[2].red)),
                     add3(SUM_W'(win[3].red), SUM_W'(win[4].red), SUM_W'(win[5].red)),
                     add3(SUM_W'(win[6].red), SUM_W'(win[7].red), SUM_W'(win[8].red)));
    tot_green = add3(add3(SUM_W'(win[0].green), SUM_W'(win[1].green), SUM_W'(win[2].green)),
                     add3(SUM_W'(win[3].green), SUM_W'(win[4].green), SUM_W'(win[5].green)),
                     add3(SUM_W'(win[6].green), SUM_W'(win[7].green), SUM_W'(win[8].green)));
    tot_blue  = add3(add3(SUM_W'(win[0].blue), SUM_W'(win[1].blue), SUM_W'(win[2].blue)),
                     add3(SUM_W'(win[3].blue), SUM_W'(win[4].blue), SUM_W'(win[5].blue)),
                     add3(SUM_W'(win[6].blue), SUM_W'(win[7].blue), SUM_W'(win[8].blue)));
  end

  // rows top to bottom: older line, newer line, incoming pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (take) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= up2;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= up1;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= s0_item.px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s2_ready) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        s2_valid <= 1'b1;
      end else if (s2_free) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_plan <= plan_new;
    end
    if (move) begin
      s2_item <= '{plan: s1_plan, tot_red: tot_red, tot_green: tot_green,
                   tot_blue: tot_blue, p4: win[4], p5: win[5], p7: win[7], p8: win[8]};
    end
  end

endmodule

>>> hdl/bb3_emit.sv
// result sequencer, divide by nine and output register
module bb3_emit import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s2_valid,
  input  calc_item_t            s2_item,
  output logic                  s2_free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic [RES_N-1:0] sent, pending, sel, rest;
  logic             out_ready, load;
  logic [COL_W-1:0] res_x, out_x;
  logic [ROW_W-1:0] res_y, out_y;
  pix_t             mean, res_px, out_px;

  assign pending   = s2_item.plan.mask & ~sent;
  assign out_ready = !m_tvalid || m_tready;

  always_comb begin
    sel = '0;
    priority case (1'b1)
      pending[RES_CENTER]: sel[RES_CENTER] = 1'b1;
      pending[RES_RIGHT]:  sel[RES_RIGHT]  = 1'b1;
      pending[RES_BELOW]:  sel[RES_BELOW]  = 1'b1;
      pending[RES_CORNER]: sel[RES_CORNER] = 1'b1;
      default:             sel = '0;
    endcase
  end

  assign rest    = pending & ~sel;
  assign load    = s2_valid && (pending != '0) && out_ready;
  // an item with no results simply drains
  assign s2_free = s2_valid && ((pending == '0) || (out_ready && rest == '0));

  assign mean = '{red:   div9_round(s2_item.tot_red),
                  green: div9_round(s2_item.tot_green),
                  blue:  div9_round(s2_item.tot_blue)};

  always_comb begin
    res_x = s2_item.plan.col;
    res_y = s2_item.plan.row;
    if (sel[RES_CENTER] || sel[RES_BELOW]) begin
      res_x = s2_item.plan.col - COL_W'(1);
    end
    if (sel[RES_CENTER] || sel[RES_RIGHT]) begin
      res_y = s2_item.plan.row - ROW_W'(1);
    end
    priority case (1'b1)
      sel[RES_CENTER]: res_px = s2_item.plan.inner ? mean : s2_item.p4;
      sel[RES_RIGHT]:  res_px = s2_item.p5;
      sel[RES_BELOW]:  res_px = s2_item.p7;
      default:         res_px = s2_item.p8;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sent     <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s2_free) begin
        sent <= '0;
      end else if (load) begin
        sent <= sent | sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x   <= res_x;
      out_y   <= res_y;
      out_px  <= res_px;
      m_tlast <= rest == '0;
    end
  end

  assign m_tdata = {(OUT_DATA_W - OUT_BITS)'(0), out_px.blue, out_px.green, out_px.red,
                    out_y, out_x};

  a_inner_coords: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_item.plan.mask[RES_CENTER] && s2_item.plan.inner) |->
      (s2_item.plan.col >= COL_W'(INNER_MIN) && s2_item.plan.row >= ROW_W'(INNER_MIN)))
    else $error("blurred pixel too close to the top or left edge");

  a_corner_plan: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_item.plan.mask[RES_CENTER] && s2_item.plan.mask[RES_CORNER]) |->
      (s2_item.plan.mask[RES_RIGHT] && s2_item.plan.mask[RES_BELOW]))
    else $error("frame corner without row end and last row results");

  a_sent_subset: assert property (@(posedge clk) disable iff (rst)
    (sent & ~(s2_valid ? s2_item.plan.mask : {RES_N{1'b0}})) == '0)
    else $error("sent results not part of the current item");

endmodule

>>> hdl/rgb_box_blur_3x3_unit.sv
// top level of the rgb 3x3 box blur: config registers and pipeline
//
//  port group  dir  beat contents
//  s_t*        in   tdata[7:0] red, [15:8] green, [23:16] blue
//  m_t*        out  tdata x, y, red, green, blue; tlast = last result of a pixel
//  apb         in   0x0 frame_width (12 bits), 0x4 frame_height (13 bits)
//
// one pixel per clock while the output takes beats; a pixel that ends a row or lies in the
// last row gives up to four results and holds back the input while its extra beats go out.
// on its way out the first result of a pixel passes the input register with line
// buffer read, window, sums, output register.
// reset is synchronous: counters, window and control clear, frame 640 x 480;
// the line buffers are not cleared. a low m_tready stops the output register,
// then the stages behind it fill and s_tready drops.
module rgb_box_blur_3x3_unit import bb3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // red, green, blue
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // x, y, red, green, blue, zero pad
  output logic                  m_tlast
);

  logic [WID_W-1:0] frame_width, w_lim;
  logic [HGT_W-1:0] frame_height, h_lim;
  logic             cfg_write;
  pix_t             in_px, up1, up2;
  logic             s0_valid, s1_ready, s2_valid, s2_free;
  front_item_t      s0_item;
  calc_item_t       s2_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[REG_IDX_BIT])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[WID_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_BIT])
      REG_FRAME_WIDTH:  prdata = CFG_DW'(frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DW'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // sizes clamped to what the line buffers and counters can hold, a zero size taken as one
  always_comb begin
    if (frame_width == '0) begin
      w_lim = WID_W'(1);
    end else if (frame_width > WID_W'(MAX_WIDTH)) begin
      w_lim = WID_W'(MAX_WIDTH);
    end else begin
      w_lim = frame_width;
    end
    if (frame_height == '0) begin
      h_lim = HGT_W'(1);
    end else if (frame_height > HGT_W'(MAX_HEIGHT)) begin
      h_lim = HGT_W'(MAX_HEIGHT);
    end else begin
      h_lim = frame_height;
    end
  end

  assign in_px = '{red:   s_tdata[CHAN_W-1:0],
                   green: s_tdata[2*CHAN_W-1:CHAN_W],
                   blue:  s_tdata[3*CHAN_W-1:2*CHAN_W]};

  bb3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .w_lim    (w_lim),
    .h_lim    (h_lim),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_px    (in_px),
    .s0_valid (s0_valid),
    .s0_item  (s0_item),
    .up1      (up1),
    .up2      (up2),
    .s1_ready (s1_ready)
  );

  bb3_window u_window (
    .clk      (clk),
    .rst      (rst),
    .w_lim    (w_lim),
    .h_lim    (h_lim),
    .s0_valid (s0_valid),
    .s0_item  (s0_item),
    .up1      (up1),
    .up2      (up2),
    .s1_ready (s1_ready),
    .s2_valid (s2_valid),
    .s2_item  (s2_item),
    .s2_free  (s2_free)
  );

  bb3_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2_item  (s2_item),
    .s2_free  (s2_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> verif/rgb_box_blur_3x3_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the rgb 3x3 box blur: directed table, clamped sizes, random frames
module rgb_box_blur_3x3_unit_tb;
  import bb3_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 12;
  localparam int RAND_PIXELS  = 280;
  localparam int FILL_WIDTH   = 16;
  localparam int CLAMP_PIXELS = 10;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_ROWS     = 24;
  localparam int RED_LSB      = COL_W + ROW_W;

  typedef struct packed {
    logic             last;
    pix_t             px;
    logic [ROW_W-1:0] y;
    logic [COL_W-1:0] x;
  } res_t;

  typedef enum logic [1:0] {ST_PIXEL, ST_WIDTH, ST_HEIGHT} step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    logic [23:0] val;    // pixel as red, green, blue, or a register value
    logic        typed;
    res_t        want;
  } dir_row_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_AW-1:0]     paddr    = '0;
  logic [CFG_DW-1:0]     pwdata   = '0;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // red, green, blue
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // x, y, red, green, blue, zero pad
  logic                  m_tlast;

  rgb_box_blur_3x3_unit u_dut (.*);

  // blur predictor state
  logic [WID_W-1:0] cfg_width  = WIDTH_RESET;
  logic [HGT_W-1:0] cfg_height = HEIGHT_RESET;
  pix_t older_line [MAX_WIDTH];
  pix_t newer_line [MAX_WIDTH];
  pix_t win [9] = '{default: '0};
  int   col_cnt = 0;
  int   row_cnt = 0;
  res_t step_out[$];
  res_t owed_pixels[$];

  int   bad_cnt     = 0;
  int   beats_seen  = 0;
  int   pixels_sent = 0;
  int   blurred_px  = 0;
  int   rand_frames = 0;
  int   cycles      = 0;
  bit   calm        = 1'b0;
  res_t mon_got;
  res_t mon_want;
  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 11);
  end

  function automatic int eff_width();
    int w;
    w = cfg_width;
    return (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  function automatic int eff_height();
    int h;
    h = cfg_height;
    return (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endfunction

  function automatic pix_t window_mean();
    int   sr, sg, sb;
    pix_t m;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int i = 0; i < 9; i++) begin
      sr += win[i].red;
      sg += win[i].green;
      sb += win[i].blue;
    end
    m.red   = CHAN_W'((sr + 4) / 9);
    m.green = CHAN_W'((sg + 4) / 9);
    m.blue  = CHAN_W'((sb + 4) / 9);
    return m;
  endfunction

  function automatic res_t at_pixel(int x, int y, pix_t p);
    res_t o;
    o.last = 1'b0;
    o.px   = p;
    o.y    = ROW_W'(y);
    o.x    = COL_W'(x);
    return o;
  endfunction

  function automatic string fmt_res(res_t r);
    return $sformatf("x=%0d y=%0d rgb=%06h last=%0d", r.x, r.y, r.px, r.last);
  endfunction

  // advance the predictor by one pixel, results land in step_out
  task automatic blur_step(input pix_t px);
    int   w, h, c, r, x, y;
    pix_t up1, up2;
    bit   inner;
    w = eff_width();
    h = eff_height();
    c = col_cnt;
    r = row_cnt;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    up2 = older_line[c];
    up1 = newer_line[c];
    // window rows are r-2, r-1, r from the top; columns c-2, c-1, c
    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;
    older_line[c] = up1;
    newer_line[c] = px;
    step_out.delete();
    if (r >= 1 && c >= 1) begin
      x = c - 1;
      y = r - 1;
      inner = x >= 2 && y >= 2 && x + 3 <= w && y + 3 <= h;
      if (inner) blurred_px++;
      step_out.push_back(at_pixel(x, y, inner ? window_mean() : win[4]));
    end
    if (r >= 1 && c == w - 1) step_out.push_back(at_pixel(c, r - 1, win[5]));
    if (r == h - 1 && c >= 1) step_out.push_back(at_pixel(c - 1, r, win[7]));
    if (r == h - 1 && c == w - 1) step_out.push_back(at_pixel(c, r, win[8]));
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  task automatic note_fault(input string msg);
    bad_cnt++;
    if (bad_cnt <= REPORT_MAX) $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      mon_got.x    = m_tdata[0 +: COL_W];
      mon_got.y    = m_tdata[COL_W +: ROW_W];
      mon_got.px   = {m_tdata[RED_LSB +: CHAN_W], m_tdata[RED_LSB + CHAN_W +: CHAN_W],
                      m_tdata[RED_LSB + 2*CHAN_W +: CHAN_W]};
      mon_got.last = m_tlast;
      beats_seen++;
      if (owed_pixels.size() == 0) begin
        note_fault({"beat with nothing owed: ", fmt_res(mon_got)});
      end else begin
        mon_want = owed_pixels.pop_front();
        if (mon_got.x !== mon_want.x || mon_got.y !== mon_want.y ||
            mon_got.px !== mon_want.px || mon_got.last !== mon_want.last)
          note_fault({"expected ", fmt_res(mon_want), ", got ", fmt_res(mon_got)});
      end
    end
  end

  task automatic send_pixel(input pix_t px, input bit typed, input res_t want);
    if (!calm && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {px.blue, px.green, px.red};
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
    blur_step(px);
    if (typed) owed_pixels.push_back(want);
    else foreach (step_out[i]) owed_pixels.push_back(step_out[i]);
  endtask

  // hold the source until every owed beat is out and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (owed_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_AW'(idx) << REG_IDX_BIT;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic write_frame_reg(input logic idx, input int unsigned val);
    logic [CFG_DW-1:0] rd, want;
    settle();
    want = (idx == REG_FRAME_WIDTH) ? CFG_DW'(val & ((1 << WID_W) - 1))
                                    : CFG_DW'(val & ((1 << HGT_W) - 1));
    apb_access(1'b1, idx, CFG_DW'(val), rd);
    apb_access(1'b0, idx, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== want) note_fault($sformatf("reg %0d read %0d, wrote %0d", idx, rd, want));
    if (idx == REG_FRAME_WIDTH) cfg_width = WID_W'(val);
    else cfg_height = HGT_W'(val);
  endtask

  function automatic pix_t rand_pixel(int mode, pix_t flat);
    pix_t p;
    case (mode)
      2: begin
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      3: p = flat;
      default: p = pix_t'(24'($urandom));
    endcase
    return p;
  endfunction

  initial begin
    logic [CFG_DW-1:0] rd;
    int   w, h, n, mode, rand_px;
    pix_t flat;

    dir_rows = '{
      // a few pixels at the reset size, then a narrower width pushes on to the next row
      '{ST_PIXEL,  24'hFFFFFF, 1'b0, '0},
      '{ST_PIXEL,  24'h000000, 1'b0, '0},
      '{ST_PIXEL,  24'h80017F, 1'b0, '0},
      '{ST_WIDTH,  24'd2,      1'b0, '0},
      '{ST_PIXEL,  24'h13579B, 1'b0, '0},
      '{ST_PIXEL,  24'hECA864, 1'b0, '0},
      // row count now past the new height, wraps to row 0
      '{ST_HEIGHT, 24'd2,      1'b0, '0},
      '{ST_PIXEL,  24'h5A5A5A, 1'b0, '0},
      // zero sizes act as one pixel frames: each pixel comes straight back
      '{ST_WIDTH,  24'd0,      1'b0, '0},
      '{ST_HEIGHT, 24'd0,      1'b0, '0},
      '{ST_PIXEL,  24'h000000, 1'b1, '{1'b1, 24'h000000, 12'd0, 11'd0}},
      '{ST_PIXEL,  24'hFFFFFF, 1'b1, '{1'b1, 24'hFFFFFF, 12'd0, 11'd0}},
      '{ST_PIXEL,  24'hA50FF0, 1'b1, '{1'b1, 24'hA50FF0, 12'd0, 11'd0}},
      // 3x3 frame: right column, bottom row and corner flush
      '{ST_WIDTH,  24'd3,      1'b0, '0},
      '{ST_HEIGHT, 24'd3,      1'b0, '0},
      '{ST_PIXEL,  24'h000000, 1'b0, '0},
      '{ST_PIXEL,  24'hFFFFFF, 1'b0, '0},
      '{ST_PIXEL,  24'h102030, 1'b0, '0},
      '{ST_PIXEL,  24'hFF00FF, 1'b0, '0},
      '{ST_PIXEL,  24'h00FF00, 1'b0, '0},
      '{ST_PIXEL,  24'h7F8081, 1'b0, '0},
      '{ST_PIXEL,  24'h010203, 1'b0, '0},
      '{ST_PIXEL,  24'hFEFDFC, 1'b0, '0},
      '{ST_PIXEL,  24'h55AA55, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_access(1'b0, REG_FRAME_WIDTH, '0, rd);
    if (rd !== CFG_DW'(WIDTH_RESET)) note_fault($sformatf("width after reset %0d", rd));
    apb_access(1'b0, REG_FRAME_HEIGHT, '0, rd);
    if (rd !== CFG_DW'(HEIGHT_RESET)) note_fault($sformatf("height after reset %0d", rd));
    psel    <= 1'b0;
    penable <= 1'b0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ST_PIXEL:  send_pixel(pix_t'(dir_rows[i].val), dir_rows[i].typed, dir_rows[i].want);
        ST_WIDTH:  write_frame_reg(REG_FRAME_WIDTH, dir_rows[i].val);
        ST_HEIGHT: write_frame_reg(REG_FRAME_HEIGHT, dir_rows[i].val);
        default:   ;
      endcase
    end

    // two rows wider than any random frame fill both line stores where they get read
    write_frame_reg(REG_FRAME_WIDTH, FILL_WIDTH);
    write_frame_reg(REG_FRAME_HEIGHT, 2);
    calm = 1'b1;
    repeat (2 * FILL_WIDTH) send_pixel(rand_pixel(0, '0), 1'b0, '0);

    // field maxima, clamped to the widest and the tallest frame
    write_frame_reg(REG_FRAME_WIDTH, (1 << WID_W) - 1);
    write_frame_reg(REG_FRAME_HEIGHT, 1);
    repeat (CLAMP_PIXELS) send_pixel(rand_pixel(0, '0), 1'b0, '0);
    write_frame_reg(REG_FRAME_WIDTH, 1);
    write_frame_reg(REG_FRAME_HEIGHT, (1 << HGT_W) - 1);
    repeat (CLAMP_PIXELS) send_pixel(rand_pixel(0, '0), 1'b0, '0);
    calm = 1'b0;

    rand_px = 0;
    while (rand_px < RAND_PIXELS) begin
      w = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 4) : $urandom_range(5, 14);
      h = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 3) : $urandom_range(4, 8);
      write_frame_reg(REG_FRAME_WIDTH, w);
      write_frame_reg(REG_FRAME_HEIGHT, h);
      n = eff_width() * eff_height();
      // some frames stop early so the next size change lands mid-frame
      if ($urandom_range(0, 99) < 20) n = $urandom_range(1, n);
      if (n > RAND_PIXELS - rand_px) n = RAND_PIXELS - rand_px;
      mode = $urandom_range(0, 3);
      flat = $urandom_range(0, 1) ? pix_t'(24'hFFFFFF) : pix_t'(24'($urandom));
      calm = (rand_frames % 7 == 4);
      repeat (n) begin
        send_pixel(rand_pixel(mode, flat), 1'b0, '0);
        rand_px++;
      end
      rand_frames++;
    end
    calm = 1'b0;

    settle();
    $display("run: %0d pixels streamed, %0d result beats checked, %0d of them box means",
             pixels_sent, beats_seen, blurred_px);
    $display("run: clamped widest and tallest sizes, %0d random frames, mid-frame size changes",
             rand_frames);
    if (bad_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
